// ===== rtl/edfw_pkg.sv =====
package edfw_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = 7;
	localparam int ID_W     = 8;
	localparam int TIME_W   = 32;
	localparam int DL_W     = TIME_W + 1;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = ID_W + TIME_W;
	localparam int OUT_DATA_W = ID_W + DL_W + CNT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BURNOUT = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic             shift;
		logic             load;
		logic [IDX_W-1:0] load_idx;
		entry_t           load_word;
	} ring_ctrl_t;

endpackage

// ===== rtl/edfw_cell.sv =====
module edfw_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load,
	input  edfw_pkg::entry_t load_word,
	input  edfw_pkg::entry_t next_word,
	output edfw_pkg::entry_t word
);

	edfw_pkg::entry_t word_q;

	// a load replaces whatever would have come from the neighbour
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end else if (shift) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule

// ===== rtl/edfw_chain.sv =====
module edfw_chain (
	input  logic                 clk,
	input  edfw_pkg::ring_ctrl_t ctrl,
	output edfw_pkg::entry_t     head
);

	edfw_pkg::entry_t words [edfw_pkg::CAPACITY];

	for (genvar k = 0; k < edfw_pkg::CAPACITY; k++) begin : g_cell
		localparam int NEXT = (k + 1) % edfw_pkg::CAPACITY;
		logic load_k;

		assign load_k = ctrl.load && (ctrl.load_idx == edfw_pkg::IDX_W'(k));

		edfw_cell u_cell (
			.clk       (clk),
			.shift     (ctrl.shift),
			.load      (load_k),
			.load_word (ctrl.load_word),
			.next_word (words[NEXT]),
			.word      (words[k])
		);
	end

	assign head = words[0];

endmodule

// ===== rtl/edf_fifo_wait_table_top.sv =====
// channel  | dir | handshake                 | payload
// s_axis   | in  | s_axis_tvalid/tready      | tuser mode, tdata coder_id, compile_time
// m_axis   | out | m_axis_tvalid/tready      | tuser status, tdata id, deadline, count
// cfg      | in  | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// add, fifo query, queries and removes on an empty table and unknown modes go
// from accept straight to the response state. remove and edf query on a
// non-empty table first scan one full turn of the cell ring past the head cell.
// the next word is taken once the result sits in the output register; a full
// output register that is not drained holds the block in its response state.
// reset clears control state only; the cells hold nothing meaningful until written.
module edf_fifo_wait_table_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [edfw_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // coder_id, compile_time
	input  logic [1:0]                        s_axis_tuser,  // mode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [edfw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // chosen_id, chosen_deadline, entry_count
	output logic [1:0]                        m_axis_tuser,  // status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [edfw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [edfw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W = edfw_pkg::IDX_W;
	localparam int CNT_W = edfw_pkg::CNT_W;
	localparam int ID_W  = edfw_pkg::ID_W;
	localparam int TW    = edfw_pkg::TIME_W;
	localparam int DL_W  = edfw_pkg::DL_W;

	edfw_pkg::state_t     state_q, state_d;
	edfw_pkg::mode_t      mode_q;
	logic [ID_W-1:0]      cmd_id_q;
	logic [TW-1:0]        cmd_time_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     step_q;
	logic                 found_q;
	logic [IDX_W-1:0]     match_q;
	logic [ID_W-1:0]      best_id_q;
	logic [DL_W-1:0]      best_dl_q;
	logic                 policy_q;
	logic [TW-1:0]        burnout_q;

	logic                 out_valid_q;
	edfw_pkg::status_t    out_status_q;
	logic [ID_W-1:0]      out_id_q;
	logic [DL_W-1:0]      out_dl_q;
	logic [CNT_W-1:0]     out_count_q;

	edfw_pkg::ring_ctrl_t ring;
	edfw_pkg::entry_t     head;
	edfw_pkg::mode_t      in_mode;
	logic                 in_fire, cfg_fire, resp_fire, needs_scan;
	logic                 last_step, active, head_match, at_tail;
	logic [DL_W-1:0]      head_dl;
	logic [CNT_W:0]       move_idx;
	edfw_pkg::status_t    res_status;
	logic [ID_W-1:0]      res_id;
	logic [DL_W-1:0]      res_dl;
	logic [CNT_W-1:0]     res_count;

	assign in_mode   = edfw_pkg::mode_t'(s_axis_tuser);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign resp_fire = (state_q == edfw_pkg::S_RESP) && (!out_valid_q || m_axis_tready);

	assign needs_scan = (count_q != '0) && ((in_mode == edfw_pkg::MODE_REMOVE) ||
		((in_mode == edfw_pkg::MODE_QUERY) && policy_q));

	assign head_dl    = {1'b0, head.stamp} + {1'b0, burnout_q};
	assign last_step  = (step_q == IDX_W'(edfw_pkg::CAPACITY - 1));
	assign active     = (CNT_W'(step_q) < count_q);
	assign head_match = active && (head.id == cmd_id_q);
	assign at_tail    = (CNT_W'(step_q) == count_q - CNT_W'(1));
	// cell that slot match_q passes into on the edge ending the tail step
	assign move_idx   = (CNT_W+1)'(edfw_pkg::CAPACITY) - {1'b0, count_q} +
		(CNT_W+1)'(match_q);

	edfw_chain u_chain (
		.clk  (clk),
		.ctrl (ring),
		.head (head)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			edfw_pkg::S_IDLE: begin
				if (in_fire) begin
					state_d = needs_scan ? edfw_pkg::S_SCAN : edfw_pkg::S_RESP;
				end
			end
			edfw_pkg::S_SCAN: begin
				if (last_step) begin
					state_d = edfw_pkg::S_RESP;
				end
			end
			edfw_pkg::S_RESP: begin
				if (resp_fire) begin
					state_d = edfw_pkg::S_IDLE;
				end
			end
			default: state_d = edfw_pkg::S_IDLE;
		endcase
	end

	// outputs: handshake and ring control
	always_comb begin
		s_axis_tready  = 1'b0;
		ring.shift     = 1'b0;
		ring.load      = 1'b0;
		ring.load_idx  = count_q[IDX_W-1:0];
		ring.load_word = '{id: cmd_id_q, stamp: cmd_time_q};
		unique case (state_q)
			edfw_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
			end
			edfw_pkg::S_SCAN: begin
				ring.shift = 1'b1;
				// last entry fills the hole left by the earlier match
				if ((mode_q == edfw_pkg::MODE_REMOVE) && at_tail && found_q) begin
					ring.load      = 1'b1;
					ring.load_idx  = move_idx[IDX_W-1:0];
					ring.load_word = head;
				end
			end
			edfw_pkg::S_RESP: begin
				if (resp_fire && (mode_q == edfw_pkg::MODE_ADD) &&
						(count_q < CNT_W'(edfw_pkg::CAPACITY))) begin
					ring.load = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result of the item in hand
	always_comb begin
		res_status = edfw_pkg::ST_IGNORED;
		res_id     = '0;
		res_dl     = '0;
		res_count  = count_q;
		unique case (mode_q)
			edfw_pkg::MODE_ADD: begin
				if (count_q < CNT_W'(edfw_pkg::CAPACITY)) begin
					res_status = edfw_pkg::ST_DONE;
					res_count  = count_q + CNT_W'(1);
				end
			end
			edfw_pkg::MODE_REMOVE: begin
				if (found_q) begin
					res_status = edfw_pkg::ST_DONE;
					res_count  = count_q - CNT_W'(1);
				end
			end
			edfw_pkg::MODE_QUERY: begin
				if (count_q == '0) begin
					res_status = edfw_pkg::ST_EMPTY;
				end else begin
					res_status = edfw_pkg::ST_DONE;
					res_id     = policy_q ? best_id_q : head.id;
					res_dl     = policy_q ? best_dl_q : head_dl;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= edfw_pkg::S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			policy_q    <= 1'b1;
			burnout_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				unique case (cfg_index)
					edfw_pkg::CFG_POLICY: begin
						policy_q <= cfg_data[0];
					end
					edfw_pkg::CFG_BURNOUT: begin
						burnout_q <= cfg_data[TW-1:0];
					end
					default: ;
				endcase
			end
			if (in_fire) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == edfw_pkg::S_SCAN) begin
				step_q <= last_step ? '0 : step_q + IDX_W'(1);
				if ((mode_q == edfw_pkg::MODE_REMOVE) && head_match && !found_q) begin
					found_q <= 1'b1;
				end
			end
			if (resp_fire) begin
				count_q     <= res_count;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q     <= in_mode;
			cmd_id_q   <= s_axis_tdata[ID_W-1:0];
			cmd_time_q <= s_axis_tdata[ID_W +: TW];
		end
		if (state_q == edfw_pkg::S_SCAN) begin
			if ((mode_q == edfw_pkg::MODE_REMOVE) && head_match && !found_q) begin
				match_q <= step_q;
			end
			if (active && ((step_q == '0) || (head_dl < best_dl_q))) begin
				best_id_q <= head.id;
				best_dl_q <= head_dl;
			end
		end
		if (resp_fire) begin
			out_status_q <= res_status;
			out_id_q     <= res_id;
			out_dl_q     <= res_dl;
			out_count_q  <= res_count;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {out_count_q, out_dl_q, out_id_q};

endmodule

// ===== rtl/edfw_check.sv =====
module edfw_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [edfw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input logic [1:0]                        s_axis_tuser,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [edfw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input logic [1:0]                        m_axis_tuser,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [edfw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [edfw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int ID_W = edfw_pkg::ID_W;
	localparam int DL_W = edfw_pkg::DL_W;

	logic [edfw_pkg::CNT_W-1:0] out_count;
	logic                       picked_zero;

	assign out_count   = m_axis_tdata[edfw_pkg::OUT_DATA_W-1 -: edfw_pkg::CNT_W];
	assign picked_zero = (m_axis_tdata[ID_W+DL_W-1:0] == '0);

	// a held result word keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
			$stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// one word in flight: busy right after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while previous word in progress");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_count <= edfw_pkg::CNT_W'(edfw_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == edfw_pkg::ST_EMPTY) |-> out_count == '0 && picked_zero)
		else $error("empty status with entries or a pick");

	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == edfw_pkg::ST_IGNORED) |-> picked_zero)
		else $error("ignored word carries a pick");

endmodule

bind edf_fifo_wait_table_top edfw_check u_edfw_check (.*);
